>>> design/wfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_pkg
// Shared types, codes and defaults of the worst-fit page extent allocator.
// ----------------------------------------------------------------------------
package wfa_pkg;

    localparam int USED_ENTRIES_DEF = 64;
    localparam int HOLE_ENTRIES_DEF = 64;
    localparam int PAGE_SHIFT_DEF   = 12;

    localparam int PAGE_W  = 20;
    localparam int PAGES_W = 21;

    // Highest usable region end: every granted start page fits in 20 bits
    localparam logic [PAGES_W-1:0] PAGE_LIMIT = 21'h100000;

    // Result status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_ZERO_SIZE = 3'd1;
    localparam logic [2:0] STATUS_NO_SPACE  = 3'd2;
    localparam logic [2:0] STATUS_NOT_ALLOC = 3'd3;
    localparam logic [2:0] STATUS_BELOW     = 3'd4;
    localparam logic [2:0] STATUS_FULL      = 3'd5;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_REGION_START = 2'd0;
    localparam logic [1:0] CFG_REGION_END   = 2'd1;

    // One free extent
    typedef struct packed {
        logic [PAGE_W-1:0]  start;
        logic [PAGES_W-1:0] pages;
    } hole_t;

    // One allocated extent
    typedef struct packed {
        logic               valid;
        logic [PAGE_W-1:0]  start;
        logic [PAGES_W-1:0] pages;
    } used_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

>>> design/wfa_hole_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_hole_cell
// One cell of the free extent ring; takes its neighbor's extent on a shift.
// ----------------------------------------------------------------------------
module wfa_hole_cell
(
    input  logic          clk,
    input  logic          shift,
    input  wfa_pkg::hole_t din,
    output wfa_pkg::hole_t dout
);

    wfa_pkg::hole_t hole_reg;

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            hole_reg <= din;
        end
    end

    assign dout = hole_reg;

endmodule

>>> design/wfa_used_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_used_cell
// One cell of the allocated extent ring; valid bit cleared on reset.
// ----------------------------------------------------------------------------
module wfa_used_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  wfa_pkg::used_t din,
    output wfa_pkg::used_t dout
);

    logic                               valid_reg;
    logic [wfa_pkg::PAGE_W-1:0]         start_reg;
    logic [wfa_pkg::PAGES_W-1:0]        pages_reg;

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= din.valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            start_reg <= din.start;
            pages_reg <= din.pages;
        end
    end

    assign dout.valid = valid_reg;
    assign dout.start = start_reg;
    assign dout.pages = pages_reg;

endmodule

>>> design/worst_fit_page_extent_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_page_extent_allocator
// Steps per request: one scan pass of both cell rings, one decision step, one
//   update pass and one output load; the output load waits while the previous
//   result is still held by the receiver. One item at a time: a new request is
//   taken only after the result of the last one has been loaded.
// Reset: no extents allocated or free, break at page 0, region end at 2^20.
// ----------------------------------------------------------------------------
module worst_fit_page_extent_allocator
#(
    parameter int USED_ENTRIES = wfa_pkg::USED_ENTRIES_DEF,
    parameter int HOLE_ENTRIES = wfa_pkg::HOLE_ENTRIES_DEF,
    parameter int PAGE_SHIFT   = wfa_pkg::PAGE_SHIFT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // size_bytes[31:0], addr_page[51:32], zero pad
    input  logic [0:0]  s_axis_tuser,   // op[0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status[2:0], result_page[22:3], zero pad
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [20:0] cfg_data
);

    localparam int MAXN  = (USED_ENTRIES > HOLE_ENTRIES) ? USED_ENTRIES : HOLE_ENTRIES;
    localparam int KW    = $clog2(MAXN) + 1;
    localparam int REQ_W = 33 - PAGE_SHIFT;
    localparam int CW    = (REQ_W > wfa_pkg::PAGES_W) ? REQ_W : wfa_pkg::PAGES_W;
    localparam int PW    = wfa_pkg::PAGE_W;
    localparam int NW    = wfa_pkg::PAGES_W;

    localparam logic [KW-1:0] H_K    = KW'(HOLE_ENTRIES);
    localparam logic [KW-1:0] U_K    = KW'(USED_ENTRIES);
    localparam logic [KW-1:0] LAST_K = KW'(MAXN - 1);
    localparam logic [KW-1:0] HLAST  = KW'(HOLE_ENTRIES - 1);
    localparam logic [32:0]   ROUND  = 33'((64'd1 << PAGE_SHIFT) - 64'd1);

    wfa_pkg::state_t state_reg, state_next;

    // configuration and global state
    logic [PW-1:0]  region_start_reg;
    logic [NW-1:0]  region_end_reg;
    logic [NW-1:0]  break_reg;
    logic [KW-1:0]  hole_count_reg;
    logic [KW-1:0]  used_count_reg;

    // request
    logic           op_reg;
    logic           size_zero_reg;
    logic [CW-1:0]  req_reg;
    logic [PW-1:0]  addr_reg;
    logic [KW-1:0]  k_reg;

    // scan results
    logic           found_reg;
    logic [KW-1:0]  best_idx_reg;
    logic [PW-1:0]  best_start_reg;
    logic [NW-1:0]  best_pages_reg;
    logic [KW-1:0]  p_reg;
    logic           lflag_reg;
    logic [PW-1:0]  lstart_reg;
    logic [NW-1:0]  lpages_reg;
    logic           rseen_reg;
    logic [PW-1:0]  rstart_reg;
    logic [NW-1:0]  rpages_reg;
    logic           slot_found_reg;
    logic [KW-1:0]  slot_reg;
    logic           match_reg;
    logic [KW-1:0]  match_idx_reg;
    logic [NW-1:0]  match_pages_reg;

    // update pass controls
    logic           ins_en_reg;
    logic [KW-1:0]  ins_idx_reg;
    logic           rem_en_reg;
    logic [KW-1:0]  rem_idx_reg;
    logic           mod_en_reg;
    logic [KW-1:0]  mod_idx_reg;
    wfa_pkg::hole_t mod_val_reg;
    wfa_pkg::hole_t new_val_reg;
    logic           u_en_reg;
    logic           u_write_reg;
    logic [KW-1:0]  u_idx_reg;
    wfa_pkg::used_t u_val_reg;
    wfa_pkg::hole_t buf_reg;

    // result
    logic [2:0]     status_reg;
    logic [PW-1:0]  page_reg;
    logic           m_valid_reg;
    logic [23:0]    m_data_reg;

    // rings
    wfa_pkg::hole_t hole_q [HOLE_ENTRIES];
    wfa_pkg::used_t used_q [USED_ENTRIES];
    wfa_pkg::hole_t hole_tail;
    wfa_pkg::used_t used_tail;
    logic           hole_shift;
    logic           used_shift;
    logic           pass_active;

    assign pass_active = (state_reg == wfa_pkg::ST_SCAN) || (state_reg == wfa_pkg::ST_UPDATE);
    assign hole_shift  = pass_active && (k_reg < H_K);
    assign used_shift  = pass_active && (k_reg < U_K);

    // Free extent ring: cell 0 is the head, the tail takes what the controller pushes
    for (genvar j = 0; j < HOLE_ENTRIES; j++)
    begin : g_hole
        wfa_hole_cell u_cell
        (
            .clk   (clk),
            .shift (hole_shift),
            .din   ((j == HOLE_ENTRIES - 1) ? hole_tail : hole_q[(j + 1) % HOLE_ENTRIES]),
            .dout  (hole_q[j])
        );
    end

    // Allocated extent ring
    for (genvar j = 0; j < USED_ENTRIES; j++)
    begin : g_used
        wfa_used_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (used_shift),
            .din   ((j == USED_ENTRIES - 1) ? used_tail : used_q[(j + 1) % USED_ENTRIES]),
            .dout  (used_q[j])
        );
    end

    // Tail push: unchanged during scan, edited stream during update
    always_comb
    begin
        hole_tail = hole_q[0];
        used_tail = used_q[0];
        if (state_reg == wfa_pkg::ST_UPDATE)
        begin
            if (ins_en_reg && (k_reg == ins_idx_reg))
            begin
                hole_tail = new_val_reg;
            end
            else if (ins_en_reg && (k_reg > ins_idx_reg))
            begin
                hole_tail = buf_reg;
            end
            else if (rem_en_reg && (k_reg >= rem_idx_reg))
            begin
                hole_tail = (k_reg < HLAST) ? hole_q[1] : hole_q[0];
            end
            else if (mod_en_reg && (k_reg == mod_idx_reg))
            begin
                hole_tail = mod_val_reg;
            end

            if (u_en_reg && (k_reg == u_idx_reg))
            begin
                used_tail = u_write_reg ? u_val_reg : '{valid: 1'b0,
                                                        start: used_q[0].start,
                                                        pages: used_q[0].pages};
            end
        end
    end

    // Decision after the scan
    logic [2:0]     d_status;
    logic [PW-1:0]  d_page;
    logic [NW-1:0]  d_break;
    logic [KW-1:0]  d_hcount;
    logic [KW-1:0]  d_ucount;
    logic           d_ins_en;
    logic           d_rem_en;
    logic [KW-1:0]  d_rem_idx;
    logic           d_mod_en;
    logic [KW-1:0]  d_mod_idx;
    wfa_pkg::hole_t d_mod_val;
    wfa_pkg::hole_t d_new_val;
    logic           d_u_en;
    logic           d_u_write;
    logic [KW-1:0]  d_u_idx;
    wfa_pkg::used_t d_u_val;

    logic [NW-1:0]  end_page;
    logic [NW-1:0]  room;
    logic [CW-1:0]  brk_x;
    logic [NW:0]    addr_end;
    logic           rf;
    logic           brk_hit;
    logic [NW-1:0]  l_sum;
    logic [NW-1:0]  r_sum;
    logic [NW-1:0]  lr_sum;
    logic [NW:0]    l_end;
    logic [NW:0]    r_end;
    logic [CW-1:0]  rem_start;
    logic [CW-1:0]  rem_pages;

    always_comb
    begin
        end_page  = (region_end_reg > wfa_pkg::PAGE_LIMIT) ? wfa_pkg::PAGE_LIMIT : region_end_reg;
        room      = end_page - break_reg;
        brk_x     = CW'(break_reg) + req_reg;
        addr_end  = {2'b00, addr_reg} + {1'b0, match_pages_reg};
        rf        = rseen_reg && (addr_end == {2'b00, rstart_reg});
        brk_hit   = (addr_end == {1'b0, break_reg});
        l_sum     = lpages_reg + match_pages_reg;
        r_sum     = match_pages_reg + rpages_reg;
        lr_sum    = l_sum + rpages_reg;
        l_end     = {2'b00, lstart_reg} + {1'b0, l_sum};
        r_end     = {2'b00, addr_reg} + {1'b0, r_sum};
        rem_start = CW'(best_start_reg) + req_reg;
        rem_pages = CW'(best_pages_reg) - req_reg;

        d_status  = wfa_pkg::STATUS_OK;
        d_page    = '0;
        d_break   = break_reg;
        d_hcount  = hole_count_reg;
        d_ucount  = used_count_reg;
        d_ins_en  = 1'b0;
        d_rem_en  = 1'b0;
        d_rem_idx = p_reg;
        d_mod_en  = 1'b0;
        d_mod_idx = p_reg;
        d_mod_val = '{start: addr_reg, pages: r_sum};
        d_new_val = '{start: addr_reg, pages: match_pages_reg};
        d_u_en    = 1'b0;
        d_u_write = 1'b0;
        d_u_idx   = match_idx_reg;
        d_u_val   = '{valid: 1'b1, start: best_start_reg, pages: req_reg[NW-1:0]};

        if (op_reg == wfa_pkg::OP_ALLOC)
        begin
            // allocate
            if (size_zero_reg)
            begin
                d_status = wfa_pkg::STATUS_ZERO_SIZE;
            end
            else if (!slot_found_reg)
            begin
                d_status = wfa_pkg::STATUS_FULL;
            end
            else if (found_reg)
            begin
                d_page    = best_start_reg;
                d_u_en    = 1'b1;
                d_u_write = 1'b1;
                d_u_idx   = slot_reg;
                d_ucount  = used_count_reg + 1'b1;
                if (CW'(best_pages_reg) > req_reg)
                begin
                    d_mod_en  = 1'b1;
                    d_mod_idx = best_idx_reg;
                    d_mod_val = '{start: rem_start[PW-1:0], pages: rem_pages[NW-1:0]};
                end
                else
                begin
                    d_rem_en  = 1'b1;
                    d_rem_idx = best_idx_reg;
                    d_hcount  = hole_count_reg - 1'b1;
                end
            end
            else if ((break_reg >= end_page) || (req_reg > CW'(room)))
            begin
                d_status = wfa_pkg::STATUS_NO_SPACE;
            end
            else
            begin
                d_page    = break_reg[PW-1:0];
                d_break   = brk_x[NW-1:0];
                d_u_en    = 1'b1;
                d_u_write = 1'b1;
                d_u_idx   = slot_reg;
                d_u_val   = '{valid: 1'b1, start: break_reg[PW-1:0], pages: req_reg[NW-1:0]};
                d_ucount  = used_count_reg + 1'b1;
            end
        end
        else
        begin
            // free
            if (addr_reg < region_start_reg)
            begin
                d_status = wfa_pkg::STATUS_BELOW;
            end
            else if (!match_reg)
            begin
                d_status = wfa_pkg::STATUS_NOT_ALLOC;
            end
            else if ((hole_count_reg >= H_K) && !lflag_reg && !rf && !brk_hit)
            begin
                d_status = wfa_pkg::STATUS_FULL;
            end
            else
            begin
                d_u_en   = 1'b1;
                d_ucount = used_count_reg - 1'b1;
                if (lflag_reg && rf)
                begin
                    // joins both neighbors
                    d_mod_en  = 1'b1;
                    d_mod_idx = p_reg - 1'b1;
                    d_mod_val = '{start: lstart_reg, pages: lr_sum};
                    d_rem_en  = 1'b1;
                    d_rem_idx = p_reg;
                    d_hcount  = hole_count_reg - 1'b1;
                end
                else if (lflag_reg)
                begin
                    if (l_end == {1'b0, break_reg})
                    begin
                        d_rem_en  = 1'b1;
                        d_rem_idx = p_reg - 1'b1;
                        d_hcount  = hole_count_reg - 1'b1;
                        d_break   = NW'(lstart_reg);
                    end
                    else
                    begin
                        d_mod_en  = 1'b1;
                        d_mod_idx = p_reg - 1'b1;
                        d_mod_val = '{start: lstart_reg, pages: l_sum};
                    end
                end
                else if (rf)
                begin
                    if (r_end == {1'b0, break_reg})
                    begin
                        d_rem_en  = 1'b1;
                        d_rem_idx = p_reg;
                        d_hcount  = hole_count_reg - 1'b1;
                        d_break   = NW'(addr_reg);
                    end
                    else
                    begin
                        d_mod_en  = 1'b1;
                        d_mod_idx = p_reg;
                    end
                end
                else if (brk_hit)
                begin
                    d_break = NW'(addr_reg);
                end
                else
                begin
                    d_ins_en = 1'b1;
                    d_hcount = hole_count_reg + 1'b1;
                end
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wfa_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = wfa_pkg::ST_SCAN;
                end
            end
            wfa_pkg::ST_SCAN:
            begin
                if (k_reg == LAST_K)
                begin
                    state_next = wfa_pkg::ST_DECIDE;
                end
            end
            wfa_pkg::ST_DECIDE:
            begin
                state_next = wfa_pkg::ST_UPDATE;
            end
            wfa_pkg::ST_UPDATE:
            begin
                if (k_reg == LAST_K)
                begin
                    state_next = wfa_pkg::ST_DONE;
                end
            end
            wfa_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = wfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control state: config, break, counts, pass counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
            region_end_reg   <= wfa_pkg::PAGE_LIMIT;
            break_reg        <= '0;
            hole_count_reg   <= '0;
            used_count_reg   <= '0;
            k_reg            <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == wfa_pkg::CFG_REGION_START)
                begin
                    region_start_reg <= cfg_data[PW-1:0];
                    if ((hole_count_reg == '0) && (used_count_reg == '0))
                    begin
                        break_reg <= NW'(cfg_data[PW-1:0]);
                    end
                end
                else if (cfg_index == wfa_pkg::CFG_REGION_END)
                begin
                    region_end_reg <= cfg_data;
                end
            end

            if (pass_active && (k_reg != LAST_K))
            begin
                k_reg <= k_reg + 1'b1;
            end
            else
            begin
                k_reg <= '0;
            end

            if (state_reg == wfa_pkg::ST_DECIDE)
            begin
                break_reg      <= d_break;
                hole_count_reg <= d_hcount;
                used_count_reg <= d_ucount;
            end

            if ((state_reg == wfa_pkg::ST_DONE) && (!m_valid_reg || m_axis_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, scan tracking, decision and result payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == wfa_pkg::ST_IDLE) && s_axis_tvalid)
        begin
            op_reg         <= s_axis_tuser[0];
            size_zero_reg  <= (s_axis_tdata[31:0] == 32'd0);
            req_reg        <= CW'(({1'b0, s_axis_tdata[31:0]} + ROUND) >> PAGE_SHIFT);
            addr_reg       <= s_axis_tdata[51:32];
            found_reg      <= 1'b0;
            p_reg          <= '0;
            lflag_reg      <= 1'b0;
            rseen_reg      <= 1'b0;
            slot_found_reg <= 1'b0;
            match_reg      <= 1'b0;
        end

        if (state_reg == wfa_pkg::ST_SCAN)
        begin
            // largest fitting hole, first one wins ties
            if ((k_reg < hole_count_reg) && (CW'(hole_q[0].pages) >= req_reg) &&
                (!found_reg || (hole_q[0].pages > best_pages_reg)))
            begin
                found_reg      <= 1'b1;
                best_idx_reg   <= k_reg;
                best_start_reg <= hole_q[0].start;
                best_pages_reg <= hole_q[0].pages;
            end
            // neighbors of the freed extent in the sorted list
            if ((k_reg < hole_count_reg) && (hole_q[0].start <= addr_reg))
            begin
                p_reg      <= k_reg + 1'b1;
                lstart_reg <= hole_q[0].start;
                lpages_reg <= hole_q[0].pages;
                lflag_reg  <= (({2'b00, hole_q[0].start} + {1'b0, hole_q[0].pages}) ==
                               {2'b00, addr_reg});
            end
            if ((k_reg < hole_count_reg) && (hole_q[0].start > addr_reg) && !rseen_reg)
            begin
                rseen_reg  <= 1'b1;
                rstart_reg <= hole_q[0].start;
                rpages_reg <= hole_q[0].pages;
            end
            // first free slot, first matching allocated start
            if ((k_reg < U_K) && !used_q[0].valid && !slot_found_reg)
            begin
                slot_found_reg <= 1'b1;
                slot_reg       <= k_reg;
            end
            if ((k_reg < U_K) && used_q[0].valid && (used_q[0].start == addr_reg) && !match_reg)
            begin
                match_reg       <= 1'b1;
                match_idx_reg   <= k_reg;
                match_pages_reg <= used_q[0].pages;
            end
        end

        if (state_reg == wfa_pkg::ST_DECIDE)
        begin
            status_reg  <= d_status;
            page_reg    <= d_page;
            ins_en_reg  <= d_ins_en;
            ins_idx_reg <= p_reg;
            rem_en_reg  <= d_rem_en;
            rem_idx_reg <= d_rem_idx;
            mod_en_reg  <= d_mod_en;
            mod_idx_reg <= d_mod_idx;
            mod_val_reg <= d_mod_val;
            new_val_reg <= d_new_val;
            u_en_reg    <= d_u_en;
            u_write_reg <= d_u_write;
            u_idx_reg   <= d_u_idx;
            u_val_reg   <= d_u_val;
        end

        // one-entry delay for the insert shift
        buf_reg <= hole_q[0];

        if ((state_reg == wfa_pkg::ST_DONE) && (!m_valid_reg || m_axis_tready))
        begin
            m_data_reg <= {1'b0, page_reg, status_reg};
        end
    end

    assign s_axis_tready = (state_reg == wfa_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign cfg_ready     = 1'b1;

endmodule

>>> bench/worst_fit_page_extent_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_page_extent_allocator_tb
// Self-checking bench for the worst-fit page extent allocator. A scoreboard
// class keeps its own copy of the used table, the sorted hole list and the
// break, predicts status and start page for every accepted request and
// compares each result transaction in order. The stimulus runs directed cases
// first, then random alloc/free traffic under three idle patterns and several
// region settings, including one long receiver stall.
// ----------------------------------------------------------------------------
module worst_fit_page_extent_allocator_tb;

    localparam int USED_N      = 64;
    localparam int HOLE_N      = 64;
    localparam int PG_SHIFT    = 12;
    localparam int SETTLE      = 2 * 64 + 12;
    localparam int LIMIT       = 2000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int RAND_ITEMS  = 125;

    typedef struct {
        logic [2:0]                 status;
        logic [wfa_pkg::PAGE_W-1:0] page;
    } alloc_result_t;

    // Allocator model plus queue of pending results
    class alloc_scoreboard;
        bit [wfa_pkg::PAGE_W-1:0]  reg_start;
        bit [wfa_pkg::PAGES_W-1:0] reg_end;
        bit [wfa_pkg::PAGE_W-1:0]  used_start [USED_N];
        bit [wfa_pkg::PAGES_W-1:0] used_pages [USED_N];
        bit                        used_valid [USED_N];
        bit [wfa_pkg::PAGE_W-1:0]  hole_start [HOLE_N];
        bit [wfa_pkg::PAGES_W-1:0] hole_pages [HOLE_N];
        int unsigned               hole_count;
        bit [wfa_pkg::PAGES_W-1:0] brk;
        alloc_result_t             results_q [$];
        int                        errors;

        function new();
            reg_start  = '0;
            reg_end    = wfa_pkg::PAGE_LIMIT;
            hole_count = 0;
            brk        = '0;
            errors     = 0;
            foreach (used_valid[i]) used_valid[i] = 1'b0;
        endfunction

        function int pending();
            return results_q.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [20:0] val);
            bit busy;
            busy = (hole_count != 0);
            foreach (used_valid[i]) if (used_valid[i]) busy = 1'b1;
            if (idx == wfa_pkg::CFG_REGION_START) begin
                reg_start = val[wfa_pkg::PAGE_W-1:0];
                if (!busy) brk = {1'b0, reg_start};
            end else if (idx == wfa_pkg::CFG_REGION_END) begin
                reg_end = val;
            end
        endfunction

        function void remove_hole(int unsigned i);
            if (i >= hole_count) return;
            for (int unsigned k = i; k + 1 < hole_count; k++) begin
                hole_start[k] = hole_start[k+1];
                hole_pages[k] = hole_pages[k+1];
            end
            hole_count--;
        endfunction

        // first hole starting above s
        function int unsigned hole_after(int unsigned s);
            int unsigned p;
            p = 0;
            while (p < hole_count && hole_start[p] <= s) p++;
            return p;
        endfunction

        function void merge_hole(int unsigned s, int unsigned n);
            int unsigned p, cur;
            p = hole_after(s);
            if (p > 0 && 32'(hole_start[p-1]) + hole_pages[p-1] == s) begin
                cur = p - 1;
                hole_pages[cur] = hole_pages[cur] + n[wfa_pkg::PAGES_W-1:0];
            end else begin
                if (hole_count >= HOLE_N) return;
                for (int unsigned k = hole_count; k > p; k--) begin
                    hole_start[k] = hole_start[k-1];
                    hole_pages[k] = hole_pages[k-1];
                end
                hole_start[p] = s[wfa_pkg::PAGE_W-1:0];
                hole_pages[p] = n[wfa_pkg::PAGES_W-1:0];
                hole_count++;
                cur = p;
            end
            if (cur + 1 < hole_count &&
                32'(hole_start[cur]) + hole_pages[cur] == hole_start[cur+1]) begin
                hole_pages[cur] = hole_pages[cur] + hole_pages[cur+1];
                remove_hole(cur + 1);
            end
            if (32'(hole_start[cur]) + hole_pages[cur] == brk) begin
                brk = {1'b0, hole_start[cur]};
                remove_hole(cur);
            end
        endfunction

        function logic [2:0] do_alloc(logic [31:0] size,
                                      output logic [wfa_pkg::PAGE_W-1:0] page);
            longint unsigned req;
            int unsigned     slot, best, lim, st, n;
            bit              found;
            page  = '0;
            found = 1'b0;
            best  = 0;
            if (size == 0) return wfa_pkg::STATUS_ZERO_SIZE;
            for (slot = 0; slot < USED_N; slot++) if (!used_valid[slot]) break;
            if (slot >= USED_N) return wfa_pkg::STATUS_FULL;
            req = (64'(size) + (64'd1 << PG_SHIFT) - 1) >> PG_SHIFT;
            for (int unsigned i = 0; i < hole_count; i++)
                if (hole_pages[i] >= req && (!found || hole_pages[i] > hole_pages[best])) begin
                    best  = i;
                    found = 1'b1;
                end
            if (found) begin
                st = hole_start[best];
                n  = hole_pages[best];
                remove_hole(best);
                if (n > req) merge_hole(st + int'(req), n - int'(req));
            end else begin
                lim = (reg_end > wfa_pkg::PAGE_LIMIT) ? wfa_pkg::PAGE_LIMIT : reg_end;
                if (brk >= lim || req > 64'(lim - brk)) return wfa_pkg::STATUS_NO_SPACE;
                st  = brk;
                brk = brk + req[wfa_pkg::PAGES_W-1:0];
            end
            used_start[slot] = st[wfa_pkg::PAGE_W-1:0];
            used_pages[slot] = req[wfa_pkg::PAGES_W-1:0];
            used_valid[slot] = 1'b1;
            page = st[wfa_pkg::PAGE_W-1:0];
            return wfa_pkg::STATUS_OK;
        endfunction

        function logic [2:0] do_free(logic [wfa_pkg::PAGE_W-1:0] addr);
            int unsigned i, p, s, n;
            bit          fresh;
            if (addr < reg_start) return wfa_pkg::STATUS_BELOW;
            for (i = 0; i < USED_N; i++) if (used_valid[i] && used_start[i] == addr) break;
            if (i >= USED_N) return wfa_pkg::STATUS_NOT_ALLOC;
            s = addr;
            n = used_pages[i];
            if (hole_count >= HOLE_N) begin
                // would this free need a new hole slot?
                p     = hole_after(s);
                fresh = 1'b1;
                if (p > 0 && 32'(hole_start[p-1]) + hole_pages[p-1] == s) fresh = 1'b0;
                if (p < hole_count && s + n == hole_start[p]) fresh = 1'b0;
                if (s + n == brk) fresh = 1'b0;
                if (fresh) return wfa_pkg::STATUS_FULL;
            end
            used_valid[i] = 1'b0;
            merge_hole(s, n);
            return wfa_pkg::STATUS_OK;
        endfunction

        // Accepted request: predict its result
        function void note_request(logic op, logic [31:0] size,
                                   logic [wfa_pkg::PAGE_W-1:0] addr);
            alloc_result_t r;
            logic [wfa_pkg::PAGE_W-1:0] pg;
            pg = '0;
            if (op == wfa_pkg::OP_ALLOC) r.status = do_alloc(size, pg);
            else                         r.status = do_free(addr);
            r.page = (r.status == wfa_pkg::STATUS_OK) ? pg : '0;
            results_q.push_back(r);
        endfunction

        // Result transaction: compare with oldest prediction
        function void check_result(logic [2:0] status, logic [wfa_pkg::PAGE_W-1:0] page);
            alloc_result_t r;
            if (results_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d page=%h", $time, status, page);
                errors++;
                return;
            end
            r = results_q.pop_front();
            if (status !== r.status) begin
                $display("%0t: status mismatch expected %0d actual %0d",
                         $time, r.status, status);
                errors++;
            end
            if (page !== r.page) begin
                $display("%0t: result_page mismatch expected %h actual %h",
                         $time, r.page, page);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // size_bytes[31:0], addr_page[51:32], zero pad
    logic [0:0]  s_axis_tuser;   // op[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // status[2:0], result_page[22:3], zero pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [20:0] cfg_data;

    alloc_scoreboard sb;
    int          tx_idle;
    int          rx_idle;
    int          hold_req;
    int          cycle_cnt;

    worst_fit_page_extent_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[2:0], m_axis_tdata[22:3]);
    end

    // Receiver: random ready, plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // One request transaction; prediction taken at acceptance
    task automatic send_req(input logic op, input logic [31:0] size, input logic [19:0] addr);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, addr, size};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_request(op, size, addr);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [20:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Start page of a random live extent, or a random page if none
    function automatic logic [19:0] live_page();
        int idx_q [$];
        foreach (sb.used_valid[i]) if (sb.used_valid[i]) idx_q.push_back(i);
        if (idx_q.size() == 0) return 20'($urandom);
        return sb.used_start[idx_q[$urandom_range(0, idx_q.size() - 1)]];
    endfunction

    task automatic free_all();
        for (int n = 0; n < 2 * USED_N; n++)
        begin
            bit any;
            any = 1'b0;
            foreach (sb.used_valid[i]) if (sb.used_valid[i]) any = 1'b1;
            if (!any) break;
            send_req(wfa_pkg::OP_FREE, 32'($urandom), live_page());
        end
    endtask

    task automatic rand_req();
        int unsigned r;
        logic [31:0] sz;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            if (r < 3)       sz = 32'd0;
            else if (r < 7)  sz = $urandom;
            else             sz = ($urandom_range(1, 4) - 1) * 4096 + $urandom_range(1, 4096);
            send_req(wfa_pkg::OP_ALLOC, sz, 20'($urandom));
        end
        else if (r < 88)
            send_req(wfa_pkg::OP_FREE, $urandom, live_page());
        else if (r < 94)
            send_req(wfa_pkg::OP_FREE, $urandom, live_page() + 20'($urandom_range(0, 2)));
        else
            send_req(wfa_pkg::OP_FREE, $urandom, 20'($urandom));
    endtask

    task automatic rand_phase(input int tx, input int rx, input bit pressure);
        tx_idle = tx;
        rx_idle = rx;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (pressure && n == 20) hold_req = 1;
            rand_req();
        end
    endtask

    initial
    begin
        sb            = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        cycle_cnt     = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tx_idle       = 0;
        rx_idle       = 0;
        hold_req      = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero size, whole region, no space, break retract
        send_req(wfa_pkg::OP_ALLOC, 32'd0, 20'h0);
        send_req(wfa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 20'h0);
        send_req(wfa_pkg::OP_ALLOC, 32'd1, 20'h0);
        send_req(wfa_pkg::OP_FREE, 32'd0, 20'h0);
        // five single pages, equal holes: first hole wins the tie
        for (int i = 0; i < 5; i++) send_req(wfa_pkg::OP_ALLOC, 32'd4096, 20'h0);
        send_req(wfa_pkg::OP_FREE, 32'd0, 20'h1);
        send_req(wfa_pkg::OP_FREE, 32'd0, 20'h3);
        send_req(wfa_pkg::OP_FREE, 32'd0, 20'h7);
        send_req(wfa_pkg::OP_ALLOC, 32'd1, 20'h0);
        // merge on both sides, then retract through the tail
        send_req(wfa_pkg::OP_FREE, 32'd0, 20'h1);
        send_req(wfa_pkg::OP_FREE, 32'd0, 20'h2);
        send_req(wfa_pkg::OP_FREE, 32'd0, 20'h0);
        send_req(wfa_pkg::OP_FREE, 32'd0, 20'h4);
        // register write with live extents does not move the break
        send_req(wfa_pkg::OP_ALLOC, 32'd8193, 20'h0);
        write_cfg(wfa_pkg::CFG_REGION_START, 21'd100);
        send_req(wfa_pkg::OP_FREE, 32'd0, 20'h0);
        send_req(wfa_pkg::OP_FREE, 32'd0, 20'd99);
        write_cfg(wfa_pkg::CFG_REGION_START, 21'd0);
        send_req(wfa_pkg::OP_FREE, 32'd0, 20'h0);

        // Used table fill, then one more alloc
        for (int i = 0; i <= USED_N; i++) send_req(wfa_pkg::OP_ALLOC, 32'd4096, 20'h0);
        free_all();

        // Top page of the space with an oversized region end
        write_cfg(wfa_pkg::CFG_REGION_START, 21'h1F_FFFF);
        write_cfg(wfa_pkg::CFG_REGION_END, 21'h1F_FFFF);
        send_req(wfa_pkg::OP_ALLOC, 32'd1, 20'h0);
        send_req(wfa_pkg::OP_ALLOC, 32'd1, 20'h0);
        send_req(wfa_pkg::OP_FREE, 32'd0, 20'hF_FFFF);
        write_cfg(wfa_pkg::CFG_REGION_END, 21'd0);
        send_req(wfa_pkg::OP_ALLOC, 32'd1, 20'h0);
        write_cfg(2'd2, 21'h15_5555);
        write_cfg(2'd3, 21'h0A_AAAA);

        // Random: wide region
        write_cfg(wfa_pkg::CFG_REGION_START, 21'd0);
        write_cfg(wfa_pkg::CFG_REGION_END, wfa_pkg::PAGE_LIMIT);
        rand_phase(38, 64, 1'b0);
        free_all();

        // Random: tight region, frequent no-space
        write_cfg(wfa_pkg::CFG_REGION_START, 21'd300);
        write_cfg(wfa_pkg::CFG_REGION_END, 21'd340);
        rand_phase(64, 38, 1'b0);
        free_all();

        // Random: high region, no idling, long receiver stall
        write_cfg(wfa_pkg::CFG_REGION_START, 21'hF_F000);
        write_cfg(wfa_pkg::CFG_REGION_END, 21'h10_0000);
        rand_phase(0, 0, 1'b1);

        wait_idle();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
